// File: rtl/core/cpl_pkg.sv
// ----------------------------------------------------------------------------
// cpl_pkg
// Shared types and widths for the closest-points-of-two-lines pipeline.
// ----------------------------------------------------------------------------
package cpl_pkg;

  // Coordinate format: signed, CW bits, FB fraction bits.
  localparam int unsigned CW = 32;
  localparam int unsigned FB = 16;

  // Dot products of two directions, and of a direction with an origin difference.
  localparam int unsigned DD_W = 2 * CW + 2;
  localparam int unsigned G_W  = 2 * CW + 3;

  // Wide signed multiplier: operands, halves, partial products, product.
  localparam int unsigned MUL_W  = G_W + 1;
  localparam int unsigned HALF_W = MUL_W / 2;
  localparam int unsigned PP_W   = 2 * HALF_W;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Determinant and numerators, and their four limbs for the point multiply.
  localparam int unsigned NUM_W  = 4 * CW + 4;
  localparam int unsigned LIMB_W = NUM_W / 4;
  localparam int unsigned PP2_W  = CW + LIMB_W;

  // Point division: dividend magnitude, remainder and quotient bits kept.
  localparam int unsigned A_W   = CW + NUM_W;
  localparam int unsigned REM_W = A_W + 2;
  localparam int unsigned QB    = CW + 1;
  localparam int unsigned SUM_W = QB + 2;

  // The threshold is shifted up by three times FB to line up with the determinant's fraction bits.
  localparam int unsigned THR_SHIFT = 3 * FB;

  // Gap: squared differences and their sum.
  localparam int unsigned SQ_W = 2 * CW;

  localparam logic [CW-1:0] THRESHOLD_RESET = CW'(66);
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW - 1){1'b0}}};

  typedef enum logic [1:0] {
    ST_SKEW     = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_ZERO_DIR = 2'd2
  } status_t;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t [2:0] vec3_t;

  typedef struct packed {
    logic signed [CW-1:0] first_origin_x;
    logic signed [CW-1:0] first_origin_y;
    logic signed [CW-1:0] first_origin_z;
    logic signed [CW-1:0] first_direction_x;
    logic signed [CW-1:0] first_direction_y;
    logic signed [CW-1:0] first_direction_z;
    logic signed [CW-1:0] second_origin_x;
    logic signed [CW-1:0] second_origin_y;
    logic signed [CW-1:0] second_origin_z;
    logic signed [CW-1:0] second_direction_x;
    logic signed [CW-1:0] second_direction_y;
    logic signed [CW-1:0] second_direction_z;
  } line_word_t;

  typedef struct packed {
    logic signed [CW-1:0] first_closest_x;
    logic signed [CW-1:0] first_closest_y;
    logic signed [CW-1:0] first_closest_z;
    logic signed [CW-1:0] second_closest_x;
    logic signed [CW-1:0] second_closest_y;
    logic signed [CW-1:0] second_closest_z;
    logic [CW-1:0]        gap;
    status_t              status;
  } result_word_t;

  typedef struct packed {
    vec3_t o1;
    vec3_t d1;
    vec3_t o2;
    vec3_t d2;
  } geo_t;

  typedef struct packed {
    geo_t                   geo;
    logic signed [DD_W-1:0] dd11;
    logic signed [DD_W-1:0] dd12;
    logic signed [DD_W-1:0] dd22;
    logic signed [G_W-1:0]  g1;
    logic signed [G_W-1:0]  g2;
  } dots_t;

  // One closest point: origin + round(direction * num / den).
  typedef struct packed {
    coord_t                  o;
    coord_t                  d;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
  } pt_in_t;

  typedef struct packed {
    vec3_t                   o;
    vec3_t                   d;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
  } line_job_t;

  typedef struct packed {
    line_job_t l1;
    line_job_t l2;
    status_t   status;
  } solve_t;

  typedef struct packed {
    vec3_t   c1;
    vec3_t   c2;
    status_t status;
  } pts_t;

endpackage

// File: rtl/core/cpl_mul.sv
// ----------------------------------------------------------------------------
// cpl_mul
// Four-stage signed multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module cpl_mul (
  input  logic                                clk,
  input  logic                                adv,
  input  logic signed [cpl_pkg::MUL_W-1:0]    a,
  input  logic signed [cpl_pkg::MUL_W-1:0]    b,
  output logic signed [cpl_pkg::PROD_W-1:0]   p
);

  logic [cpl_pkg::MUL_W-1:0]  am;
  logic [cpl_pkg::MUL_W-1:0]  bm;
  logic                       sgn_a;
  logic                       sgn_b;
  logic                       sgn_c;
  logic [cpl_pkg::PP_W-1:0]   pp00;
  logic [cpl_pkg::PP_W-1:0]   pp01;
  logic [cpl_pkg::PP_W-1:0]   pp10;
  logic [cpl_pkg::PP_W-1:0]   pp11;
  logic [cpl_pkg::PROD_W-1:0] mag;

  always_ff @(posedge clk) begin
    if (adv) begin
      // Sign and magnitude of both operands.
      sgn_a <= a[cpl_pkg::MUL_W-1] ^ b[cpl_pkg::MUL_W-1];
      am    <= a[cpl_pkg::MUL_W-1] ? cpl_pkg::MUL_W'(-a) : cpl_pkg::MUL_W'(a);
      bm    <= b[cpl_pkg::MUL_W-1] ? cpl_pkg::MUL_W'(-b) : cpl_pkg::MUL_W'(b);

      sgn_b <= sgn_a;
      pp00  <= cpl_pkg::PP_W'(am[cpl_pkg::HALF_W-1:0]) *
               cpl_pkg::PP_W'(bm[cpl_pkg::HALF_W-1:0]);
      pp01  <= cpl_pkg::PP_W'(am[cpl_pkg::HALF_W-1:0]) *
               cpl_pkg::PP_W'(bm[cpl_pkg::MUL_W-1:cpl_pkg::HALF_W]);
      pp10  <= cpl_pkg::PP_W'(am[cpl_pkg::MUL_W-1:cpl_pkg::HALF_W]) *
               cpl_pkg::PP_W'(bm[cpl_pkg::HALF_W-1:0]);
      pp11  <= cpl_pkg::PP_W'(am[cpl_pkg::MUL_W-1:cpl_pkg::HALF_W]) *
               cpl_pkg::PP_W'(bm[cpl_pkg::MUL_W-1:cpl_pkg::HALF_W]);

      sgn_c <= sgn_b;
      mag   <= {pp11, pp00} +
               ((cpl_pkg::PROD_W'(pp01) + cpl_pkg::PROD_W'(pp10)) << cpl_pkg::HALF_W);

      p     <= sgn_c ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

// File: rtl/core/cpl_dots.sv
// ----------------------------------------------------------------------------
// cpl_dots
// Three stages: origin difference, products, and the five dot products.
// ----------------------------------------------------------------------------
module cpl_dots (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  cpl_pkg::line_word_t  lines,
  output logic                 out_valid,
  output cpl_pkg::dots_t       dots
);

  localparam int unsigned E_W = cpl_pkg::CW + 1;
  localparam int unsigned P_W = 2 * cpl_pkg::CW;
  localparam int unsigned Q_W = cpl_pkg::CW + E_W;

  cpl_pkg::geo_t            geo_in;
  cpl_pkg::geo_t            geo1;
  cpl_pkg::geo_t            geo2;
  logic                     v1;
  logic                     v2;
  logic signed [E_W-1:0]    e1 [3];
  logic signed [P_W-1:0]    p11 [3];
  logic signed [P_W-1:0]    p12 [3];
  logic signed [P_W-1:0]    p22 [3];
  logic signed [Q_W-1:0]    q1 [3];
  logic signed [Q_W-1:0]    q2 [3];

  always_comb begin
    geo_in.o1[0] = lines.first_origin_x;
    geo_in.o1[1] = lines.first_origin_y;
    geo_in.o1[2] = lines.first_origin_z;
    geo_in.d1[0] = lines.first_direction_x;
    geo_in.d1[1] = lines.first_direction_y;
    geo_in.d1[2] = lines.first_direction_z;
    geo_in.o2[0] = lines.second_origin_x;
    geo_in.o2[1] = lines.second_origin_y;
    geo_in.o2[2] = lines.second_origin_z;
    geo_in.d2[0] = lines.second_direction_x;
    geo_in.d2[1] = lines.second_direction_y;
    geo_in.d2[2] = lines.second_direction_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo1 <= geo_in;
      for (int i = 0; i < 3; i++) begin
        e1[i] <= E_W'($signed(geo_in.o2[i])) - E_W'($signed(geo_in.o1[i]));
      end

      geo2 <= geo1;
      for (int i = 0; i < 3; i++) begin
        p11[i] <= P_W'($signed(geo1.d1[i])) * P_W'($signed(geo1.d1[i]));
        p12[i] <= P_W'($signed(geo1.d1[i])) * P_W'($signed(geo1.d2[i]));
        p22[i] <= P_W'($signed(geo1.d2[i])) * P_W'($signed(geo1.d2[i]));
        q1[i]  <= Q_W'($signed(geo1.d1[i])) * Q_W'(e1[i]);
        q2[i]  <= Q_W'($signed(geo1.d2[i])) * Q_W'(e1[i]);
      end

      dots.geo  <= geo2;
      dots.dd11 <= cpl_pkg::DD_W'(p11[0]) + cpl_pkg::DD_W'(p11[1]) +
                   cpl_pkg::DD_W'(p11[2]);
      dots.dd12 <= cpl_pkg::DD_W'(p12[0]) + cpl_pkg::DD_W'(p12[1]) +
                   cpl_pkg::DD_W'(p12[2]);
      dots.dd22 <= cpl_pkg::DD_W'(p22[0]) + cpl_pkg::DD_W'(p22[1]) +
                   cpl_pkg::DD_W'(p22[2]);
      dots.g1   <= cpl_pkg::G_W'(q1[0]) + cpl_pkg::G_W'(q1[1]) + cpl_pkg::G_W'(q1[2]);
      dots.g2   <= cpl_pkg::G_W'(q2[0]) + cpl_pkg::G_W'(q2[1]) + cpl_pkg::G_W'(q2[2]);
    end
  end

endmodule

// File: rtl/core/cpl_solve.sv
// ----------------------------------------------------------------------------
// cpl_solve
// Determinant and numerators, parallel test, and the per-line division jobs.
// ----------------------------------------------------------------------------
module cpl_solve (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic [cpl_pkg::CW-1:0]  threshold,
  input  logic                    in_valid,
  input  cpl_pkg::dots_t          dots,
  output logic                    out_valid,
  output cpl_pkg::solve_t         job
);

  localparam int unsigned MUL_LAT = 4;

  logic signed [cpl_pkg::MUL_W-1:0]  ma [6];
  logic signed [cpl_pkg::MUL_W-1:0]  mb [6];
  logic signed [cpl_pkg::PROD_W-1:0] mp [6];

  logic           side_v [MUL_LAT];
  cpl_pkg::dots_t side   [MUL_LAT];

  logic                            vx;
  logic                            vy;
  cpl_pkg::dots_t                  dx;
  cpl_pkg::dots_t                  dy;
  logic signed [cpl_pkg::NUM_W-1:0] fx;
  logic signed [cpl_pkg::NUM_W-1:0] fy;
  logic signed [cpl_pkg::NUM_W-1:0] n1x;
  logic signed [cpl_pkg::NUM_W-1:0] n1y;
  logic signed [cpl_pkg::NUM_W-1:0] n2x;
  logic signed [cpl_pkg::NUM_W-1:0] n2y;
  logic [cpl_pkg::NUM_W-1:0]        absf;
  logic                             fzero;
  logic                             dzero;
  logic [cpl_pkg::NUM_W-1:0]        thr_wide;
  logic                             par;

  always_comb begin
    ma[0] = cpl_pkg::MUL_W'(dots.dd11); mb[0] = cpl_pkg::MUL_W'(dots.dd22);
    ma[1] = cpl_pkg::MUL_W'(dots.dd12); mb[1] = cpl_pkg::MUL_W'(dots.dd12);
    ma[2] = cpl_pkg::MUL_W'(dots.dd22); mb[2] = cpl_pkg::MUL_W'(dots.g1);
    ma[3] = cpl_pkg::MUL_W'(dots.dd12); mb[3] = cpl_pkg::MUL_W'(dots.g2);
    ma[4] = cpl_pkg::MUL_W'(dots.dd12); mb[4] = cpl_pkg::MUL_W'(dots.g1);
    ma[5] = cpl_pkg::MUL_W'(dots.dd11); mb[5] = cpl_pkg::MUL_W'(dots.g2);
  end

  for (genvar m = 0; m < 6; m++) begin : g_mul
    cpl_mul u_mul (
      .clk (clk),
      .adv (adv),
      .a   (ma[m]),
      .b   (mb[m]),
      .p   (mp[m])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MUL_LAT; k++) side_v[k] <= 1'b0;
      vx        <= 1'b0;
      vy        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      side_v[0] <= in_valid;
      for (int k = 1; k < MUL_LAT; k++) side_v[k] <= side_v[k-1];
      vx        <= side_v[MUL_LAT-1];
      vy        <= vx;
      out_valid <= vy;
    end
  end

  always_comb begin
    thr_wide = cpl_pkg::NUM_W'(threshold) << cpl_pkg::THR_SHIFT;
    // A zero determinant counts as parallel even with a zero threshold.
    par      = fzero || (absf < thr_wide);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= dots;
      for (int k = 1; k < MUL_LAT; k++) side[k] <= side[k-1];

      dx  <= side[MUL_LAT-1];
      fx  <= cpl_pkg::NUM_W'(mp[0] - mp[1]);
      n1x <= cpl_pkg::NUM_W'(mp[2] - mp[3]);
      n2x <= cpl_pkg::NUM_W'(mp[4] - mp[5]);

      dy    <= dx;
      fy    <= fx;
      n1y   <= n1x;
      n2y   <= n2x;
      absf  <= fx[cpl_pkg::NUM_W-1] ? cpl_pkg::NUM_W'(-fx) : cpl_pkg::NUM_W'(fx);
      fzero <= (fx == '0);
      dzero <= (dx.dd11 == '0);

      job.l1.o <= dy.geo.o1;
      job.l1.d <= dy.geo.d1;
      job.l2.o <= dy.geo.o2;
      job.l2.d <= dy.geo.d2;
      if (par) begin
        // Second point stays at its origin: zero over one.
        job.l2.num <= '0;
        job.l2.den <= cpl_pkg::NUM_W'(1);
        if (dzero) begin
          job.l1.num <= '0;
          job.l1.den <= cpl_pkg::NUM_W'(1);
          job.status <= cpl_pkg::ST_ZERO_DIR;
        end else begin
          job.l1.num <= cpl_pkg::NUM_W'(dy.g1);
          job.l1.den <= cpl_pkg::NUM_W'(dy.dd11);
          job.status <= cpl_pkg::ST_PARALLEL;
        end
      end else begin
        job.l1.num <= n1y;
        job.l1.den <= fy;
        job.l2.num <= n2y;
        job.l2.den <= fy;
        job.status <= cpl_pkg::ST_SKEW;
      end
    end
  end

endmodule

// File: rtl/core/cpl_point.sv
// ----------------------------------------------------------------------------
// cpl_point
// One closest-point coordinate: wide multiply, pipelined restoring division
// with round-half-away, then add to the origin and saturate.
// ----------------------------------------------------------------------------
module cpl_point (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  cpl_pkg::status_t              in_tag,
  input  cpl_pkg::pt_in_t               pt,
  output logic                          out_valid,
  output cpl_pkg::status_t              out_tag,
  output logic signed [cpl_pkg::CW-1:0] coord
);

  localparam int unsigned DEPTH = cpl_pkg::QB + 1;
  localparam int unsigned B_W   = cpl_pkg::NUM_W + 1;

  logic                              v1, v2, v3;
  cpl_pkg::status_t                  t1, t2, t3;
  cpl_pkg::coord_t                   o1, o2, o3;
  logic                              neg1, neg2, neg3;
  logic [cpl_pkg::CW-1:0]            dmag1;
  logic [cpl_pkg::NUM_W-1:0]         nmag1;
  logic [cpl_pkg::NUM_W-1:0]         den1, den2, den3;
  logic [cpl_pkg::PP2_W-1:0]         pp2 [4];
  logic [cpl_pkg::A_W-1:0]           amag3;

  logic                              dv_v   [DEPTH+1];
  cpl_pkg::status_t                  dv_tag [DEPTH+1];
  cpl_pkg::coord_t                   dv_o   [DEPTH+1];
  logic                              dv_neg [DEPTH+1];
  logic [B_W-1:0]                    dv_b   [DEPTH+1];
  logic [cpl_pkg::REM_W-1:0]         dv_rem [DEPTH+1];
  logic [cpl_pkg::QB:0]              dv_q   [DEPTH+1];

  logic [cpl_pkg::SUM_W-1:0]         qmag;
  logic signed [cpl_pkg::SUM_W-1:0]  qsig;
  logic signed [cpl_pkg::SUM_W-1:0]  sum;
  logic signed [cpl_pkg::CW-1:0]     coord_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      dv_v[0]  <= 1'b0;
    end else if (adv) begin
      v1       <= in_valid;
      v2       <= v1;
      v3       <= v2;
      dv_v[0]  <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1    <= in_tag;
      o1    <= pt.o;
      neg1  <= pt.d[cpl_pkg::CW-1] ^ pt.num[cpl_pkg::NUM_W-1] ^ pt.den[cpl_pkg::NUM_W-1];
      dmag1 <= pt.d[cpl_pkg::CW-1] ? cpl_pkg::CW'(-pt.d) : cpl_pkg::CW'(pt.d);
      nmag1 <= pt.num[cpl_pkg::NUM_W-1] ? cpl_pkg::NUM_W'(-pt.num)
                                        : cpl_pkg::NUM_W'(pt.num);
      den1  <= pt.den[cpl_pkg::NUM_W-1] ? cpl_pkg::NUM_W'(-pt.den)
                                        : cpl_pkg::NUM_W'(pt.den);

      t2   <= t1;
      o2   <= o1;
      neg2 <= neg1;
      den2 <= den1;
      for (int k = 0; k < 4; k++) begin
        pp2[k] <= cpl_pkg::PP2_W'(dmag1) *
                  cpl_pkg::PP2_W'(nmag1[k*cpl_pkg::LIMB_W +: cpl_pkg::LIMB_W]);
      end

      // Even limbs do not overlap and concatenate; odd limbs sit one limb higher.
      t3    <= t2;
      o3    <= o2;
      neg3  <= neg2;
      den3  <= den2;
      amag3 <= cpl_pkg::A_W'({pp2[2], 1'b0, pp2[0]}) +
               (cpl_pkg::A_W'({pp2[3], 1'b0, pp2[1]}) << cpl_pkg::LIMB_W);

      // Rounded quotient is floor((2|a| + |den|) / (2|den|)).
      dv_tag[0] <= t3;
      dv_o[0]   <= o3;
      dv_neg[0] <= neg3;
      dv_b[0]   <= {den3, 1'b0};
      dv_rem[0] <= cpl_pkg::REM_W'({amag3, 1'b0}) + cpl_pkg::REM_W'(den3);
      dv_q[0]   <= '0;
    end
  end

  // One quotient bit per stage, top bit first; the top bit flags overflow.
  for (genvar j = 1; j <= DEPTH; j++) begin : g_div
    localparam int unsigned K = DEPTH - j;
    logic [cpl_pkg::REM_W-1:0] trial;
    logic                      ge;

    always_comb begin
      trial = cpl_pkg::REM_W'(dv_b[j-1]) << K;
      ge    = (dv_rem[j-1] >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (adv) begin
        dv_v[j] <= dv_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_tag[j] <= dv_tag[j-1];
        dv_o[j]   <= dv_o[j-1];
        dv_neg[j] <= dv_neg[j-1];
        dv_b[j]   <= dv_b[j-1];
        dv_rem[j] <= ge ? dv_rem[j-1] - trial : dv_rem[j-1];
        dv_q[j]   <= dv_q[j-1] | ((cpl_pkg::QB + 1)'(ge) << K);
      end
    end
  end

  always_comb begin
    qmag = cpl_pkg::SUM_W'(dv_q[DEPTH][cpl_pkg::QB-1:0]);
    qsig = dv_neg[DEPTH] ? -$signed(qmag) : $signed(qmag);
    sum  = cpl_pkg::SUM_W'(dv_o[DEPTH]) + qsig;
    priority if (dv_q[DEPTH][cpl_pkg::QB]) begin
      coord_next = dv_neg[DEPTH] ? cpl_pkg::COORD_MIN : cpl_pkg::COORD_MAX;
    end else if (sum > cpl_pkg::SUM_W'(cpl_pkg::COORD_MAX)) begin
      coord_next = cpl_pkg::COORD_MAX;
    end else if (sum < cpl_pkg::SUM_W'(cpl_pkg::COORD_MIN)) begin
      coord_next = cpl_pkg::COORD_MIN;
    end else begin
      coord_next = cpl_pkg::CW'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tag <= dv_tag[DEPTH];
      coord   <= coord_next;
    end
  end

endmodule

// File: rtl/core/cpl_gap.sv
// ----------------------------------------------------------------------------
// cpl_gap
// Squared distance of the two points and a pipelined integer square root;
// the last stage is the block's output register.
// ----------------------------------------------------------------------------
module cpl_gap (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  cpl_pkg::pts_t         pts,
  output logic                  out_valid,
  output cpl_pkg::result_word_t result
);

  localparam int unsigned D_W = cpl_pkg::CW + 1;
  localparam int unsigned R_W = cpl_pkg::SQ_W + 1;
  localparam int unsigned S_W = cpl_pkg::SQ_W + 2;

  logic                         v1, v2;
  cpl_pkg::pts_t                p1, p2;
  logic [cpl_pkg::CW-1:0]       mag1 [3];
  logic [cpl_pkg::SQ_W-1:0]     sq2  [3];
  logic signed [D_W-1:0]        diff [3];
  logic [S_W-1:0]               ssum;

  logic                         rt_v    [cpl_pkg::CW+1];
  cpl_pkg::pts_t                rt_pts  [cpl_pkg::CW+1];
  logic                         rt_sat  [cpl_pkg::CW+1];
  logic [R_W-1:0]               rt_rem  [cpl_pkg::CW+1];
  logic [cpl_pkg::CW-1:0]       rt_root [cpl_pkg::CW+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = D_W'($signed(pts.c1[i])) - D_W'($signed(pts.c2[i]));
    end
    ssum = S_W'(sq2[0]) + S_W'(sq2[1]) + S_W'(sq2[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      rt_v[0]  <= 1'b0;
    end else if (adv) begin
      v1       <= in_valid;
      v2       <= v1;
      rt_v[0]  <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= pts;
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= diff[i][D_W-1] ? cpl_pkg::CW'(-diff[i]) : cpl_pkg::CW'(diff[i]);
      end

      p2 <= p1;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= cpl_pkg::SQ_W'(mag1[i]) * cpl_pkg::SQ_W'(mag1[i]);
      end

      // A root of 2^CW or more does not fit: the gap saturates.
      rt_pts[0]  <= p2;
      rt_sat[0]  <= |ssum[S_W-1:cpl_pkg::SQ_W];
      rt_rem[0]  <= R_W'(ssum[cpl_pkg::SQ_W-1:0]);
      rt_root[0] <= '0;
    end
  end

  // Square root one bit per stage: (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k).
  for (genvar j = 1; j <= cpl_pkg::CW; j++) begin : g_root
    localparam int unsigned K = cpl_pkg::CW - j;
    logic [R_W-1:0] delta;
    logic           ge;

    always_comb begin
      delta = (R_W'(rt_root[j-1]) << (K + 1)) + (R_W'(1) << (2 * K));
      ge    = (rt_rem[j-1] >= delta);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[j] <= 1'b0;
      end else if (adv) begin
        rt_v[j] <= rt_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_pts[j]  <= rt_pts[j-1];
        rt_sat[j]  <= rt_sat[j-1];
        rt_rem[j]  <= ge ? rt_rem[j-1] - delta : rt_rem[j-1];
        rt_root[j] <= rt_root[j-1] | (cpl_pkg::CW'(ge) << K);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= rt_v[cpl_pkg::CW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.first_closest_x  <= rt_pts[cpl_pkg::CW].c1[0];
      result.first_closest_y  <= rt_pts[cpl_pkg::CW].c1[1];
      result.first_closest_z  <= rt_pts[cpl_pkg::CW].c1[2];
      result.second_closest_x <= rt_pts[cpl_pkg::CW].c2[0];
      result.second_closest_y <= rt_pts[cpl_pkg::CW].c2[1];
      result.second_closest_z <= rt_pts[cpl_pkg::CW].c2[2];
      result.gap              <= rt_sat[cpl_pkg::CW] ? '1 : rt_root[cpl_pkg::CW];
      result.status           <= rt_pts[cpl_pkg::CW].status;
    end
  end

endmodule

// File: rtl/core/closest_points_two_lines.sv
// ----------------------------------------------------------------------------
// closest_points_two_lines
// Mutually closest points of two 3D lines in signed Q16.16, with their
// distance and a parallel / degenerate status.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                Word
//   --------  -------------------------------------  -------------------------
//   input     line_valid / line_stall / lines        two origins, directions
//   output    result_valid / result_stall / result   two points, gap, status
//   config    write_enable / write_data              parallel threshold
//
// One word is accepted every cycle unless the result stalls; latency is set mostly by
// the two bit-per-stage units: the point division (one quotient bit per stage,
// 34 stages) and the gap square root (one root bit per stage, 32 stages).
// Synchronous reset clears all valid bits and loads the threshold with 66.
// A stalled result holds every stage in place, so line_stall follows
// result_valid and result_stall, and no word is lost or repeated.
//
// Dataflow: cpl_dots forms the five dot products, cpl_solve forms the
// determinant and numerators on wide pipelined multipliers and decides the
// parallel case, six cpl_point units give the rounded and saturated point
// coordinates, and cpl_gap forms the distance and holds the output register.
// ----------------------------------------------------------------------------
module closest_points_two_lines (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    line_valid,
  output logic                    line_stall,
  input  cpl_pkg::line_word_t     lines,
  output logic                    result_valid,
  input  logic                    result_stall,
  output cpl_pkg::result_word_t   result,
  input  logic                    write_enable,
  input  logic [cpl_pkg::CW-1:0]  write_data
);

  logic                     adv;
  logic [cpl_pkg::CW-1:0]   threshold;
  logic                     dots_valid;
  cpl_pkg::dots_t           dots;
  logic                     solve_valid;
  cpl_pkg::solve_t          job;
  cpl_pkg::pt_in_t          pt1 [3];
  cpl_pkg::pt_in_t          pt2 [3];
  logic                     pt_valid1 [3];
  logic                     pt_valid2 [3];
  cpl_pkg::status_t         pt_tag1 [3];
  cpl_pkg::status_t         pt_tag2 [3];
  cpl_pkg::coord_t          c1 [3];
  cpl_pkg::coord_t          c2 [3];
  cpl_pkg::pts_t            pts;

  // The whole pipeline moves unless a finished word is waiting on the output.
  assign adv        = !(result_valid && result_stall);
  assign line_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= cpl_pkg::THRESHOLD_RESET;
    end else if (write_enable) begin
      threshold <= write_data;
    end
  end

  cpl_dots u_dots (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (line_valid),
    .lines     (lines),
    .out_valid (dots_valid),
    .dots      (dots)
  );

  cpl_solve u_solve (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .threshold (threshold),
    .in_valid  (dots_valid),
    .dots      (dots),
    .out_valid (solve_valid),
    .job       (job)
  );

  // Both lines share one job format, so all six coordinates use the same cpl_point module.
  for (genvar i = 0; i < 3; i++) begin : g_axis
    always_comb begin
      pt1[i].o   = job.l1.o[i];
      pt1[i].d   = job.l1.d[i];
      pt1[i].num = job.l1.num;
      pt1[i].den = job.l1.den;
      pt2[i].o   = job.l2.o[i];
      pt2[i].d   = job.l2.d[i];
      pt2[i].num = job.l2.num;
      pt2[i].den = job.l2.den;
    end

    cpl_point u_pt1 (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (solve_valid),
      .in_tag    (job.status),
      .pt        (pt1[i]),
      .out_valid (pt_valid1[i]),
      .out_tag   (pt_tag1[i]),
      .coord     (c1[i])
    );

    cpl_point u_pt2 (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (solve_valid),
      .in_tag    (job.status),
      .pt        (pt2[i]),
      .out_valid (pt_valid2[i]),
      .out_tag   (pt_tag2[i]),
      .coord     (c2[i])
    );
  end

  // All six units run in lockstep; the first one carries valid and status.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pts.c1[i] = c1[i];
      pts.c2[i] = c2[i];
    end
    pts.status = pt_tag1[0];
  end

  cpl_gap u_gap (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (pt_valid1[0]),
    .pts       (pts),
    .out_valid (result_valid),
    .result    (result)
  );

endmodule
